// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GWW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define GWW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gww_pkg.sv =====
// ---------------------------------------------------------------------------
// gww_pkg
// types and constants shared by the greedy word wrap block
// ---------------------------------------------------------------------------
package gww_pkg;

  typedef logic [7:0] char_t;
  typedef logic [7:0] width_t;

  localparam char_t  CHAR_SPACE    = 8'd32;
  localparam char_t  CHAR_NEWLINE  = 8'd10;
  localparam width_t DEFAULT_WIDTH = 8'd80;

endpackage

// ===== rtl/gww_in_if.sv =====
// ---------------------------------------------------------------------------
// gww_in_if
// input channel: one text byte per word with end-of-text mark
// ---------------------------------------------------------------------------
interface gww_in_if;
  logic              valid;
  logic              ready;
  gww_pkg::char_t    in_char;
  logic              in_end_of_text;

  modport source (output valid, output in_char, output in_end_of_text, input ready);
  modport sink   (input valid, input in_char, input in_end_of_text, output ready);
endinterface

// ===== rtl/gww_out_if.sv =====
// ---------------------------------------------------------------------------
// gww_out_if
// output channel: one emitted byte per word with run, text and truncation flags
// ---------------------------------------------------------------------------
interface gww_out_if;
  logic              valid;
  logic              ready;
  gww_pkg::char_t    out_char;
  logic              end_of_run;
  logic              end_of_text;
  logic              word_truncated;

  modport source (output valid, output out_char, output end_of_run, output end_of_text,
                  output word_truncated, input ready);
  modport sink   (input valid, input out_char, input end_of_run, input end_of_text,
                  input word_truncated, output ready);
endinterface

// ===== rtl/gww_ram.sv =====
// ---------------------------------------------------------------------------
// gww_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/greedy_word_wrap_unit.sv =====
// ---------------------------------------------------------------------------
// greedy_word_wrap_unit
// greedy word wrap: buffers each word and replays it after a separator
// ---------------------------------------------------------------------------
// usage:
//   din carries one text byte per word; byte 32 ends a word, and a word
//   with in_end_of_text set also ends the word and the text.
//   dout carries the wrapped stream: a space or newline before every word
//   but the first of a text, then the word bytes.
//   line_width_we / line_width_wdata write the line width (reset 80);
//   write it only while the block is idle.
// timing:
//   a byte that does not end a word is taken while din stays ready.
//   a byte that ends a non-empty word holds din until its last word byte
//   is loaded into dout. the word buffer memory is read one byte a cycle
//   with registered read data, so one word byte leaves per cycle while
//   dout is ready. a pending separator is loaded into dout first, then
//   each word byte once its read data is registered.
// reset clears the word and line state and sets the width to 80.
// a stall on dout holds the output register and pauses the buffer reads.
// ---------------------------------------------------------------------------
module greedy_word_wrap_unit #(
  parameter int MAX_WORD = 63
) (
  input  logic            clk,
  input  logic            rst,
  gww_in_if.sink          din,
  gww_out_if.source       dout,
  input  logic            line_width_we,
  input  gww_pkg::width_t line_width_wdata
);
  import gww_pkg::*;

  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LW = $clog2(MAX_WORD + 1);

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t          state;
  width_t          line_width;
  logic [LW-1:0]   word_len;
  logic            word_ovf;
  logic [7:0]      line_len;
  logic [LW-1:0]   emit_len;
  logic            emit_trunc;
  logic            emit_eot;
  logic [LW-1:0]   rd_ptr;
  logic [LW-1:0]   ld_cnt;
  logic            rdata_ok;
  logic            sep_pend;
  char_t           sep_char;
  logic            out_valid;
  char_t           out_char;
  logic            out_eor;
  logic            out_eot;
  logic            out_trunc;
  char_t           ram_rdata;

  logic            in_acc;
  logic            is_space;
  logic            buf_wr;
  logic [LW-1:0]   new_len;
  logic            new_ovf;
  logic            flush;
  logic [8:0]      line_sum;
  logic            fits;
  logic            out_free;
  logic            load_sep;
  logic            load_chr;
  logic            last_chr;
  logic            issue;

  always_comb begin
    in_acc   = din.valid && din.ready;
    is_space = (din.in_char == CHAR_SPACE);
    buf_wr   = !is_space && (word_len < LW'(MAX_WORD));
    new_len  = buf_wr ? word_len + LW'(1) : word_len;
    new_ovf  = word_ovf || (!is_space && (word_len == LW'(MAX_WORD)));
    flush    = is_space || din.in_end_of_text;
    line_sum = {1'b0, line_len} + 9'd1 + 9'(new_len);
    fits     = (line_sum <= {1'b0, line_width});

    out_free = !out_valid || dout.ready;
    load_sep = (state == ST_EMIT) && sep_pend && out_free;
    load_chr = (state == ST_EMIT) && !sep_pend && rdata_ok && out_free;
    last_chr = (ld_cnt == emit_len - LW'(1));
    issue    = (state == ST_EMIT) && (rd_ptr != emit_len) && (!rdata_ok || load_chr);
  end

  assign din.ready           = (state == ST_IDLE);
  assign dout.valid          = out_valid;
  assign dout.out_char       = out_char;
  assign dout.end_of_run     = out_eor;
  assign dout.end_of_text    = out_eot;
  assign dout.word_truncated = out_trunc;

  gww_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD)
  ) u_word_ram (
    .clk   (clk),
    .we    (in_acc && buf_wr),
    .waddr (word_len[AW-1:0]),
    .wdata (din.in_char),
    .re    (issue),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_width <= DEFAULT_WIDTH;
      word_len   <= '0;
      word_ovf   <= 1'b0;
      line_len   <= '0;
      rd_ptr     <= '0;
      ld_cnt     <= '0;
      rdata_ok   <= 1'b0;
      sep_pend   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (line_width_we) begin
        line_width <= line_width_wdata;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (flush) begin
              word_len <= '0;
              word_ovf <= 1'b0;
              if (new_len != '0) begin
                state      <= ST_EMIT;
                emit_len   <= new_len;
                emit_trunc <= new_ovf;
                emit_eot   <= din.in_end_of_text;
                rd_ptr     <= '0;
                ld_cnt     <= '0;
                rdata_ok   <= 1'b0;
                sep_pend   <= (line_len != '0);
                sep_char   <= fits ? CHAR_SPACE : CHAR_NEWLINE;
                if (din.in_end_of_text) begin
                  line_len <= '0;
                end else if (line_len != '0 && fits) begin
                  line_len <= line_sum[7:0];
                end else begin
                  line_len <= 8'(new_len);
                end
              end else if (din.in_end_of_text) begin
                line_len <= '0;
              end
            end else begin
              word_len <= new_len;
              word_ovf <= new_ovf;
            end
          end
        end
        ST_EMIT: begin
          if (load_sep) begin
            sep_pend <= 1'b0;
          end
          if (issue) begin
            rd_ptr   <= rd_ptr + LW'(1);
            rdata_ok <= 1'b1;
          end else if (load_chr) begin
            rdata_ok <= 1'b0;
          end
          if (load_chr) begin
            ld_cnt <= ld_cnt + LW'(1);
            if (last_chr) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (load_sep) begin
        out_valid <= 1'b1;
        out_char  <= sep_char;
        out_eor   <= 1'b0;
        out_eot   <= 1'b0;
        out_trunc <= 1'b0;
      end else if (load_chr) begin
        out_valid <= 1'b1;
        out_char  <= ram_rdata;
        out_eor   <= last_chr;
        out_eot   <= last_chr && emit_eot;
        out_trunc <= last_chr && emit_trunc;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/gww_checker.sv =====
// ---------------------------------------------------------------------------
// gww_checker
// port-level checks for the greedy word wrap block, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gww_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input gww_pkg::char_t out_char,
  input logic           end_of_run,
  input logic           end_of_text,
  input logic           word_truncated
);
  import gww_pkg::*;

  // a text ends only on the last byte of a run
  `GWW_ASSERT_NOW(a_eot_ends_run, clk, rst, out_valid && end_of_text, end_of_run)

  // a truncated mark sits on a word byte that closes the run
  `GWW_ASSERT_NOW(a_trunc_on_word_end, clk, rst, out_valid && word_truncated,
                  end_of_run && out_char != CHAR_SPACE)

  // input stops only after a byte was taken
  `GWW_ASSERT_NOW(a_ready_drop_after_take, clk, rst, $fell(in_ready),
                  $past(in_valid))

  // stalled output holds
  `GWW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_char) && $stable(end_of_run))

endmodule

bind greedy_word_wrap_unit gww_checker u_gww_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (din.valid),
  .in_ready       (din.ready),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .out_char       (dout.out_char),
  .end_of_run     (dout.end_of_run),
  .end_of_text    (dout.end_of_text),
  .word_truncated (dout.word_truncated)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for greedy_word_wrap_unit
// ---------------------------------------------------------------------------
// A short table of text bytes runs first: the first word, collapsed spaces,
// odd byte values, an empty end, the narrowest and widest line widths, a word
// longer than the line and a word longer than the buffer. A few rows carry
// their wrapped output spelled out. The rest are checked against a wrap
// predictor kept in the bench. Random texts follow in three phases with
// different sender and receiver idle rates. Each phase changes the width
// between texts. One text runs under a long receiver hold-off.
// ---------------------------------------------------------------------------
module tb;
  import gww_pkg::*;

  localparam int WORD_MAX     = 63;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int GAP_MAX      = 40;

  typedef struct packed {
    char_t ch;
    logic  run_end;
    logic  text_end;
    logic  trunc;
  } wrap_byte_t;

  typedef struct {
    bit    typed;
    string txt;
  } typed_exp_t;

  // ch holds the width on a set_width row
  typedef struct {
    bit    set_width;
    char_t ch;
    logic  eot;
    int    rep;
    bit    typed;
    string txt;
  } text_row_t;

  logic   clk = 1'b0;
  logic   rst;
  logic   line_width_we;
  width_t line_width_wdata;

  gww_in_if  din_if ();
  gww_out_if dout_if ();

  greedy_word_wrap_unit #(.MAX_WORD(WORD_MAX)) dut (
    .clk              (clk),
    .rst              (rst),
    .din              (din_if),
    .dout             (dout_if),
    .line_width_we    (line_width_we),
    .line_width_wdata (line_width_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_t       word_buf [$];
  int unsigned word_len;
  bit          word_ovf;
  int unsigned line_len;
  width_t      line_w;

  wrap_byte_t wrapped_q [$];
  typed_exp_t typed_q [$];
  int         fail_count = 0;
  int         items_sent = 0;
  int         src_idle   = 0;
  int         snk_idle   = 0;
  bit         hold_req   = 1'b0;

  function automatic int wrap_step(char_t c, logic eot);
    wrap_byte_t b;
    int n;
    n = 0;
    if (c != CHAR_SPACE) begin
      if (word_len < WORD_MAX) begin
        word_buf.push_back(c);
        word_len++;
      end else begin
        word_ovf = 1'b1;
      end
    end
    if ((c == CHAR_SPACE || eot) && word_len != 0) begin
      b = '0;
      if (line_len == 0) begin
        line_len = word_len;
      end else if (line_len + 1 + word_len <= line_w) begin
        b.ch = CHAR_SPACE;
        wrapped_q.push_back(b);
        n++;
        line_len = line_len + 1 + word_len;
      end else begin
        b.ch = CHAR_NEWLINE;
        wrapped_q.push_back(b);
        n++;
        line_len = word_len;
      end
      for (int i = 0; i < word_len; i++) begin
        b.ch = word_buf[i];
        b.trunc = word_ovf && (i == word_len - 1);
        wrapped_q.push_back(b);
        n++;
      end
      word_buf.delete();
      word_len = 0;
      word_ovf = 1'b0;
    end
    if (n > 0) begin
      b = wrapped_q.pop_back();
      b.run_end = 1'b1;
      b.text_end = eot;
      wrapped_q.push_back(b);
    end
    if (eot) begin
      word_buf.delete();
      word_len = 0;
      word_ovf = 1'b0;
      line_len = 0;
    end
    return n;
  endfunction

  always @(posedge clk) begin : predictor
    int n;
    typed_exp_t fx;
    wrap_byte_t b;
    if (rst) begin
      word_buf.delete();
      word_len = 0;
      word_ovf = 1'b0;
      line_len = 0;
      line_w   = DEFAULT_WIDTH;
    end else begin
      if (line_width_we) line_w = line_width_wdata;
      if (din_if.valid && din_if.ready) begin
        n = wrap_step(din_if.in_char, din_if.in_end_of_text);
        fx = typed_q.pop_front();
        if (fx.typed) begin
          repeat (n) void'(wrapped_q.pop_back());
          for (int i = 0; i < fx.txt.len(); i++) begin
            b = '0;
            b.ch = fx.txt[i];
            b.run_end = (i == fx.txt.len() - 1);
            b.text_end = b.run_end && din_if.in_end_of_text;
            wrapped_q.push_back(b);
          end
        end
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : compare_out
    wrap_byte_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (wrapped_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, actual %0h", $time, dout_if.out_char);
      end else begin
        want = wrapped_q.pop_front();
        check_field("out_char", want.ch, dout_if.out_char);
        check_field("end_of_run", 8'(want.run_end), 8'(dout_if.end_of_run));
        check_field("end_of_text", 8'(want.text_end), 8'(dout_if.end_of_text));
        check_field("word_truncated", 8'(want.trunc), 8'(dout_if.word_truncated));
      end
    end
  end

  initial begin : receiver
    dout_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        dout_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        dout_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(char_t c, logic eot, bit typed, string txt);
    int gap;
    typed_exp_t fx;
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(99) < src_idle) gap++;
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fx.typed = typed;
    fx.txt = txt;
    typed_q.push_back(fx);
    din_if.valid <= 1'b1;
    din_if.in_char <= c;
    din_if.in_end_of_text <= eot;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    din_if.valid <= 1'b0;
    @(posedge clk);
    while (wrapped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(width_t w);
    wait_idle();
    line_width_we <= 1'b1;
    line_width_wdata <= w;
    @(posedge clk);
    line_width_we <= 1'b0;
  endtask

  task automatic send_text(int max_words);
    char_t txt [$];
    char_t c;
    int n_words;
    int wlen;
    int r;
    n_words = $urandom_range(max_words, 1);
    if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) txt.push_back(CHAR_SPACE);
    for (int w = 0; w < n_words; w++) begin
      r = $urandom_range(99);
      if (r < 3) wlen = 0;
      else if (r < 8) wlen = $urandom_range(70, 55);
      else wlen = $urandom_range(10, 1);
      repeat (wlen) begin
        do c = 8'($urandom_range(255)); while (c == CHAR_SPACE);
        txt.push_back(c);
      end
      if (w < n_words - 1)
        repeat (($urandom_range(9) == 0) ? $urandom_range(3, 2) : 1) txt.push_back(CHAR_SPACE);
      else if ($urandom_range(4) == 0)
        repeat ($urandom_range(2, 1)) txt.push_back(CHAR_SPACE);
    end
    if (txt.size() == 0) txt.push_back(CHAR_SPACE);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1, 1'b0, "");
  endtask

  initial begin : stimulus
    text_row_t dir_rows [29];
    int stop;
    bit pressed;
    dir_rows = '{
      '{0, "h",          0, 1,  1, ""},
      '{0, "i",          0, 1,  1, ""},
      '{0, CHAR_SPACE,   0, 1,  1, "hi"},
      '{0, CHAR_SPACE,   0, 1,  1, ""},
      '{0, 8'h00,        0, 1,  1, ""},
      '{0, 8'hff,        0, 1,  1, ""},
      '{0, CHAR_NEWLINE, 0, 1,  1, ""},
      '{0, CHAR_SPACE,   0, 1,  0, ""},
      '{0, "x",          1, 1,  1, " x"},
      '{0, CHAR_SPACE,   1, 1,  1, ""},
      '{0, "q",          1, 1,  1, "q"},
      '{1, 8'd1,         0, 0,  0, ""},
      '{0, "a",          0, 1,  1, ""},
      '{0, CHAR_SPACE,   0, 1,  1, "a"},
      '{0, "b",          0, 1,  1, ""},
      '{0, CHAR_SPACE,   0, 1,  1, "\nb"},
      '{0, "c",          1, 1,  1, "\nc"},
      '{1, 8'd3,         0, 0,  0, ""},
      '{0, "a",          0, 2,  0, ""},
      '{0, CHAR_SPACE,   0, 1,  1, "aa"},
      '{0, "c",          0, 5,  0, ""},
      '{0, CHAR_SPACE,   0, 1,  1, "\nccccc"},
      '{0, "d",          1, 1,  1, "\nd"},
      '{1, 8'd255,       0, 0,  0, ""},
      '{0, "w",          0, 70, 0, ""},
      '{0, CHAR_SPACE,   0, 1,  0, ""},
      '{0, "y",          1, 1,  1, " y"},
      '{0, "v",          0, 63, 0, ""},
      '{0, "v",          1, 1,  0, ""}
    };
    pressed = 1'b0;
    rst <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.in_char <= '0;
    din_if.in_end_of_text <= 1'b0;
    line_width_we <= 1'b0;
    line_width_wdata <= DEFAULT_WIDTH;
    src_idle = 36;
    snk_idle = 70;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_width) begin
        write_width(dir_rows[i].ch);
      end else begin
        for (int k = 0; k < dir_rows[i].rep; k++)
          send_byte(dir_rows[i].ch, dir_rows[i].eot && (k == dir_rows[i].rep - 1),
                    dir_rows[i].typed, dir_rows[i].txt);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle = 36;
          snk_idle = 70;
        end
        1: begin
          src_idle = 70;
          snk_idle = 36;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      write_width((phase == 0) ? 8'd1 : (phase == 1) ? 8'd255 : 8'($urandom_range(40, 2)));
      stop = items_sent + 60;
      while (items_sent < stop) begin
        if ($urandom_range(1) == 0) begin
          case ($urandom_range(9))
            0: write_width(8'd1);
            1: write_width(8'd255);
            default: write_width(8'($urandom_range(40, 2)));
          endcase
        end
        if (phase == 2 && !pressed) begin
          // long receiver hold-off while a long text keeps coming
          hold_req = 1'b1;
          pressed = 1'b1;
          send_text(12);
        end else begin
          send_text(8);
        end
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
